[hdl/sbe_pkg.sv]
// shared types and codes for the stack bytecode executor
package sbe_pkg;

    // operation codes carried in req_type
    localparam logic [2:0] REQ_PUSH  = 3'd0;
    localparam logic [2:0] REQ_ADD   = 3'd1;
    localparam logic [2:0] REQ_SUB   = 3'd2;
    localparam logic [2:0] REQ_STORE = 3'd3;
    localparam logic [2:0] REQ_CALL  = 3'd4;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_UNDER  = 3'd1,
        ST_OVER   = 3'd2,
        ST_BADSYM = 3'd3,
        ST_CALL   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        STK_HOLD    = 2'd0,
        STK_PUSH    = 2'd1,
        STK_REPLACE = 2'd2,
        STK_POP2    = 2'd3
    } stk_cmd_t;

    // one update command for the stack slots
    typedef struct packed {
        stk_cmd_t    cmd;
        logic [63:0] value;
    } stk_req_t;

    // one result beat
    typedef struct packed {
        status_t            status;
        logic [4:0]         depth_now;
        logic signed [63:0] top_value;
        logic               store_done;
        logic [3:0]         store_slot;
        logic signed [63:0] store_data;
    } result_t;

endpackage

[hdl/sbe_ifs.sv]
// valid/ready channel interfaces for instruction and result beats

interface sbe_instr_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic signed [63:0] operand;

    modport source (output valid, output req_type, output operand, input ready);
    modport sink   (input valid, input req_type, input operand, output ready);
endinterface

interface sbe_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [4:0]         depth_now;
    logic signed [63:0] top_value;
    logic               store_done;
    logic [3:0]         store_slot;
    logic signed [63:0] store_data;

    modport source (output valid, output status, output depth_now, output top_value,
                    output store_done, output store_slot, output store_data,
                    input ready);
    modport sink   (input valid, input status, input depth_now, input top_value,
                    input store_done, input store_slot, input store_data,
                    output ready);
endinterface

[hdl/sbe_stack.sv]
// evaluation stack as a row of shifting slots, top at slot 0
module sbe_stack #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sbe_pkg::stk_req_t              req,
    output logic [$clog2(STACK_DEPTH+1)-1:0] count,
    output logic [63:0]                    top0,
    output logic [63:0]                    top1,
    output logic [63:0]                    top2
);
    import sbe_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [63:0]   slot_reg  [STACK_DEPTH];
    logic [63:0]   slot_next [STACK_DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_slot
        logic [63:0] from_above;
        logic [63:0] from_below1;
        logic [63:0] from_below2;
        logic [63:0] nxt;

        if (i == 0) begin : g_top
            assign from_above = req.value;
        end else begin : g_mid
            assign from_above = slot_reg[i-1];
        end

        if (i + 1 < STACK_DEPTH) begin : g_b1
            assign from_below1 = slot_reg[i+1];
        end else begin : g_b1_end
            assign from_below1 = slot_reg[i];
        end

        if (i + 2 < STACK_DEPTH) begin : g_b2
            assign from_below2 = slot_reg[i+2];
        end else begin : g_b2_end
            assign from_below2 = slot_reg[i];
        end

        always_comb
        begin
            unique case (req.cmd)
                STK_PUSH:    nxt = from_above;
                STK_REPLACE: nxt = (i == 0) ? req.value : from_below1;
                STK_POP2:    nxt = from_below2;
                default:     nxt = slot_reg[i];
            endcase
        end

        assign slot_next[i] = nxt;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

    always_comb
    begin
        unique case (req.cmd)
            STK_PUSH:    count_next = count_reg + CW'(1);
            STK_REPLACE: count_next = count_reg - CW'(1);
            STK_POP2:    count_next = count_reg - CW'(2);
            default:     count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;
    assign top0  = slot_reg[0];
    assign top1  = slot_reg[1];

    if (STACK_DEPTH > 2) begin : g_top2
        assign top2 = slot_reg[2];
    end else begin : g_no_top2
        assign top2 = '0;
    end

endmodule

[hdl/stack_bytecode_executor.sv]
// top level of the stack bytecode executor
//
// executes one stack instruction per instruction beat and returns exactly one result
// beat for it. the block takes one instruction every cycle while instr.ready is high:
// decode, the 64-bit add or subtract and the error checks form a single combinational
// pass from the stack slot registers to the result register, and the evaluation stack
// is a row of STACK_DEPTH registered slots that shift by zero, one or two places per
// cycle with the top three entries always at hand. each result is registered in the
// output register, or in the single skid entry while the consumer stalls; instr.ready
// drops only while both hold beats, and rises as soon as the consumer takes one. push
// places the operand on the stack, add and subtract pop rhs (top) and lhs and push
// the wrapping result, store pops the value and the symbol index below it. the symbol
// write itself is delivered on the result beat (store_done, store_slot, store_data)
// for the symbol memory that sits downstream. call, unknown operations, underflow,
// overflow and an index not below SYMBOL_COUNT report an error status and change
// nothing. after reset the stack is empty; no clearing pass is needed.
module stack_bytecode_executor #(
    parameter int STACK_DEPTH  = 16,
    parameter int SYMBOL_COUNT = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    sbe_instr_if.sink     instr,
    sbe_result_if.source  result
);
    import sbe_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    // stack view and command
    stk_req_t      stk_req;
    logic [CW-1:0] stk_count;
    logic [63:0]   top0;
    logic [63:0]   top1;
    logic [63:0]   top2;

    // output register and skid entry
    result_t result_reg;
    result_t result_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t skid_reg;
    result_t skid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;

    logic    accept;
    result_t res_new;
    stk_cmd_t cmd;
    logic [63:0]   alu_value;
    logic [CW-1:0] count_after;
    logic [CW+4:0] count_ext;
    logic          full;
    logic          has2;

    assign instr.ready = !skid_valid_reg;
    assign accept      = instr.valid && instr.ready;

    assign full = (stk_count == CW'(STACK_DEPTH));
    assign has2 = (stk_count >= CW'(2));

    // add or subtract of the top two entries, lhs below rhs
    assign alu_value = (instr.req_type == REQ_SUB) ? (top1 - top0) : (top1 + top0);

    // decode and checks for one instruction
    always_comb
    begin
        cmd                = STK_HOLD;
        count_after        = stk_count;
        res_new.status     = ST_OK;
        res_new.top_value  = (stk_count == '0) ? 64'sd0 : $signed(top0);
        res_new.store_done = 1'b0;
        res_new.store_slot = 4'd0;
        res_new.store_data = 64'sd0;

        unique case (instr.req_type) inside
            REQ_PUSH:
            begin
                if (full)
                begin
                    res_new.status = ST_OVER;
                end
                else
                begin
                    cmd               = STK_PUSH;
                    count_after       = stk_count + CW'(1);
                    res_new.top_value = instr.operand;
                end
            end
            REQ_ADD, REQ_SUB:
            begin
                if (!has2)
                begin
                    res_new.status = ST_UNDER;
                end
                else
                begin
                    cmd               = STK_REPLACE;
                    count_after       = stk_count - CW'(1);
                    res_new.top_value = $signed(alu_value);
                end
            end
            REQ_STORE:
            begin
                if (!has2)
                begin
                    res_new.status = ST_UNDER;
                end
                else if (top1 >= 64'(SYMBOL_COUNT))
                begin
                    // symbol index beyond the store
                    res_new.status = ST_BADSYM;
                end
                else
                begin
                    cmd                = STK_POP2;
                    count_after        = stk_count - CW'(2);
                    res_new.top_value  = (stk_count > CW'(2)) ? $signed(top2) : 64'sd0;
                    res_new.store_done = 1'b1;
                    res_new.store_slot = top1[3:0];
                    res_new.store_data = $signed(top0);
                end
            end
            default:
            begin
                // call and unused codes
                res_new.status = ST_CALL;
            end
        endcase

        count_ext         = {5'd0, count_after};
        res_new.depth_now = count_ext[4:0];
    end

    // stack moves only on an accepted beat
    assign stk_req.cmd   = accept ? cmd : STK_HOLD;
    assign stk_req.value = (instr.req_type == REQ_PUSH) ? instr.operand : alu_value;

    sbe_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (stk_req),
        .count (stk_count),
        .top0  (top0),
        .top1  (top1),
        .top2  (top2)
    );

    // output register with one skid entry behind it
    always_comb
    begin
        result_next     = result_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (!out_valid_reg || result.ready)
        begin
            if (skid_valid_reg)
            begin
                result_next     = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                result_next    = res_new;
                out_valid_next = accept;
            end
        end
        else if (accept)
        begin
            // consumer stalled, park the new beat
            skid_next       = res_new;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        skid_reg   <= skid_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.status     = result_reg.status;
    assign result.depth_now  = result_reg.depth_now;
    assign result.top_value  = result_reg.top_value;
    assign result.store_done = result_reg.store_done;
    assign result.store_slot = result_reg.store_slot;
    assign result.store_data = result_reg.store_data;

    // stack never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stk_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // skid entry is only used behind a waiting output beat
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid beat without output beat");

    // an accepted push on a stack with room grows it by one
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && instr.req_type == REQ_PUSH && !full)
        |=> stk_count == $past(stk_count) + CW'(1))
        else $error("push did not grow the stack");

    // a store on the result beat always reports success
    a_store_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.store_done) |-> result_reg.status == ST_OK)
        else $error("store beat with error status");

endmodule
